[src/srpg_pkg.sv]
// Shared constants, codes and types for the stepper ramp pulse generator.
// No dependencies; compiled first.
package srpg_pkg;

  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned PERIOD_BITS = 24;
  localparam int unsigned TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned LEN_W       = 9;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef logic [PERIOD_BITS-1:0] period_t;

  // input word function codes (3 is treated as a tick)
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_WRITE = 2'd2;

  // run status codes
  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_LIMIT  = 2'd2;
  localparam logic [1:0] ST_SAFETY = 2'd3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONST_PER   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEPS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WIDTH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_SETUP   = 3'd5;

  // configuration reset values
  localparam period_t            RST_CONST_PER   = PERIOD_BITS'(1000);
  localparam logic [LEN_W-1:0]   RST_TABLE_LEN   = 9'd1;
  localparam logic [31:0]        RST_MAX_STEPS   = 32'hFFFF_FFFF;
  localparam logic [7:0]         RST_PULSE_WIDTH = 8'd5;
  localparam logic [7:0]         RST_DIR_SETUP   = 8'd20;

  typedef struct packed {
    logic              wr_en;
    logic [TBL_AW-1:0] wr_addr;
    period_t           wr_data;
  } tbl_wr_t;

endpackage

[src/srpg_if.sv]
// Handshake channels of the stepper ramp pulse generator: input word,
// result word and configuration write. Depends on srpg_pkg.
interface srpg_in_if;
  import srpg_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic             limit_hit;
  logic             forward;
  logic [IDX_W-1:0] table_index;
  logic [23:0]      table_value;

  modport source (output valid, func, limit_hit, forward, table_index, table_value,
                  input ready);
  modport sink   (input valid, func, limit_hit, forward, table_index, table_value,
                  output ready);
endinterface

interface srpg_out_if;
  logic               valid;
  logic               ready;
  logic               step_out;
  logic               dir_out;
  logic [1:0]         status;
  logic [31:0]        steps_done;
  logic signed [31:0] position;

  modport source (output valid, step_out, dir_out, status, steps_done, position,
                  input ready);
  modport sink   (input valid, step_out, dir_out, status, steps_done, position,
                  output ready);
endinterface

interface srpg_cfg_if;
  import srpg_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[src/stepper_ramp_pulse_generator_unit.sv]
// Top level of the stepper ramp pulse generator: tick/start/table-write
// processing, configuration registers and result handshake.
// Depends on srpg_pkg, srpg_if and srpg_period_table.

// One input word is taken per clock cycle: each word (a microsecond tick, a
// start or a table write) is processed as it is taken and its result word
// is the register state left behind, held on out_o until taken. in_i.ready is
// high whenever no result is pending or the pending one is taken in the same
// cycle, so with out_o.ready high the block sustains one word per cycle. The
// ramp table is a 256 x 24 synchronous RAM; its read is prefetched one step
// ahead so a step or the end of the direction setup can load its period in
// the same cycle. The table needs no clearing pass and is not touched by
// reset. Configuration writes are always accepted and take effect at once.
module stepper_ramp_pulse_generator_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  srpg_in_if.sink   in_i,
  srpg_out_if.source out_o,
  srpg_cfg_if.sink  cfg_i
);
  import srpg_pkg::*;

  // configuration
  logic             use_table_q;
  period_t          const_per_q;
  logic [LEN_W-1:0] table_len_q;
  logic [LEN_W-1:0] table_len_d;
  logic [31:0]      max_steps_q;
  logic [7:0]       pulse_width_q;
  logic [7:0]       dir_setup_q;

  // motion state
  logic [1:0]         run_q, run_d;
  logic               in_setup_q, in_setup_d;
  period_t            countdown_q, countdown_d;
  logic [7:0]         pulse_left_q, pulse_left_d;
  logic [31:0]        step_cnt_q, step_cnt_d;
  logic signed [31:0] pos_q, pos_d;
  logic               dir_q, dir_d;
  logic               out_valid_q, out_valid_d;

  logic     accept;
  tbl_wr_t  tbl_wr;
  period_t  tbl_rd;
  period_t  period_raw;
  period_t  period_sel;
  period_t  cd_dec;

  assign accept      = in_i.valid && in_i.ready;
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign cfg_i.ready = 1'b1;

  // prefetch sees a table length write in the cycle it lands
  assign table_len_d = (cfg_i.valid && cfg_i.index == CFG_TABLE_LEN) ?
                       cfg_i.data[LEN_W-1:0] : table_len_q;

  assign period_raw = use_table_q ? tbl_rd : const_per_q;
  assign period_sel = (period_raw == '0) ? PERIOD_BITS'(1) : period_raw;
  assign cd_dec     = (countdown_q != '0) ? countdown_q - PERIOD_BITS'(1) : countdown_q;

  always_comb begin
    run_d        = run_q;
    in_setup_d   = in_setup_q;
    countdown_d  = countdown_q;
    pulse_left_d = pulse_left_q;
    step_cnt_d   = step_cnt_q;
    pos_d        = pos_q;
    dir_d        = dir_q;
    tbl_wr       = '0;
    tbl_wr.wr_addr = in_i.table_index[TBL_AW-1:0];
    tbl_wr.wr_data = PERIOD_BITS'(in_i.table_value);

    if (accept) begin
      unique case (in_i.func)
        FUNC_START: begin
          if (run_q != ST_RUN) begin
            step_cnt_d = '0;
            if (in_i.limit_hit) begin
              run_d = ST_LIMIT;
            end else begin
              dir_d       = in_i.forward;
              run_d       = ST_RUN;
              in_setup_d  = 1'b1;
              countdown_d = PERIOD_BITS'(dir_setup_q);
            end
          end
        end
        FUNC_WRITE: begin
          if (run_q != ST_RUN && {1'b0, in_i.table_index} < LEN_W'(TABLE_DEPTH)) begin
            tbl_wr.wr_en = 1'b1;
          end
        end
        default: begin
          if (pulse_left_q != '0) begin
            pulse_left_d = pulse_left_q - 8'd1;
          end
          if (run_q == ST_RUN) begin
            countdown_d = cd_dec;
            if (cd_dec == '0) begin
              if (in_setup_q) begin
                in_setup_d  = 1'b0;
                countdown_d = period_sel;
              end else if (in_i.limit_hit) begin
                run_d = ST_LIMIT;
              end else begin
                pulse_left_d = pulse_width_q;
                pos_d        = pos_q + (dir_q ? 32'sd1 : -32'sd1);
                step_cnt_d   = step_cnt_q + 32'd1;
                if (step_cnt_d >= max_steps_q) begin
                  run_d = ST_SAFETY;
                end else begin
                  countdown_d = period_sel;
                end
              end
            end
          end
        end
      endcase
    end

    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  srpg_period_table u_table (
    .clk_i     (clk_i),
    .wr_i      (tbl_wr),
    .setup_i   (in_setup_d),
    .step_i    (step_cnt_d),
    .len_i     (table_len_d),
    .rd_data_o (tbl_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      use_table_q   <= 1'b0;
      const_per_q   <= RST_CONST_PER;
      table_len_q   <= RST_TABLE_LEN;
      max_steps_q   <= RST_MAX_STEPS;
      pulse_width_q <= RST_PULSE_WIDTH;
      dir_setup_q   <= RST_DIR_SETUP;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_USE_TABLE:   use_table_q   <= cfg_i.data[0];
        CFG_CONST_PER:   const_per_q   <= cfg_i.data[PERIOD_BITS-1:0];
        CFG_TABLE_LEN:   table_len_q   <= cfg_i.data[LEN_W-1:0];
        CFG_MAX_STEPS:   max_steps_q   <= cfg_i.data;
        CFG_PULSE_WIDTH: pulse_width_q <= cfg_i.data[7:0];
        CFG_DIR_SETUP:   dir_setup_q   <= cfg_i.data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= ST_IDLE;
      in_setup_q   <= 1'b0;
      countdown_q  <= '0;
      pulse_left_q <= '0;
      step_cnt_q   <= '0;
      pos_q        <= '0;
      dir_q        <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      run_q        <= run_d;
      in_setup_q   <= in_setup_d;
      countdown_q  <= countdown_d;
      pulse_left_q <= pulse_left_d;
      step_cnt_q   <= step_cnt_d;
      pos_q        <= pos_d;
      dir_q        <= dir_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // result word is the state after the last accepted input word
  assign out_o.valid      = out_valid_q;
  assign out_o.step_out   = (pulse_left_q != '0);
  assign out_o.dir_out    = dir_q;
  assign out_o.status     = run_q;
  assign out_o.steps_done = step_cnt_q;
  assign out_o.position   = pos_q;

  a_setup_only_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_setup_q |-> run_q == ST_RUN)
    else $error("setup wait outside a move");

  a_countdown_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q == ST_RUN && !in_setup_q) |-> countdown_q != '0)
    else $error("running without a pending step period");

  a_step_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(step_cnt_q) |-> (step_cnt_q == $past(step_cnt_q) + 32'd1 || step_cnt_q == '0))
    else $error("step count jumped");

  a_pos_with_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(pos_q) |-> (step_cnt_q == $past(step_cnt_q) + 32'd1 &&
                         pulse_left_q == $past(pulse_width_q)))
    else $error("position moved without a step");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> $stable(step_cnt_q) && $stable(run_q))
    else $error("state changed while a result was pending");

endmodule

[src/srpg_period_table.sv]
// Ramp period table: synchronous RAM plus the clamped read address.
// Depends on srpg_pkg.
module srpg_period_table (
  input  logic                     clk_i,
  input  srpg_pkg::tbl_wr_t        wr_i,
  input  logic                     setup_i,
  input  logic [31:0]              step_i,
  input  logic [srpg_pkg::LEN_W-1:0] len_i,
  output srpg_pkg::period_t        rd_data_o
);
  import srpg_pkg::*;

  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  last_idx;
  logic [32:0]       next_idx;
  logic [TBL_AW-1:0] rd_addr;
  period_t           mem_q [TABLE_DEPTH];
  period_t           rd_data_q;

  // prefetch the period needed at the next load: entry 0 during setup,
  // otherwise the entry for the step after the current count, clamped to the last entry
  always_comb begin
    if (len_i == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_i > LEN_W'(TABLE_DEPTH)) begin
      len_eff = LEN_W'(TABLE_DEPTH);
    end else begin
      len_eff = len_i;
    end
    last_idx = len_eff - LEN_W'(1);
    next_idx = {1'b0, step_i} + 33'd1;
    if (setup_i) begin
      rd_addr = '0;
    end else if (next_idx < 33'(len_eff)) begin
      rd_addr = next_idx[TBL_AW-1:0];
    end else begin
      rd_addr = last_idx[TBL_AW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.wr_en) begin
      mem_q[wr_i.wr_addr] <= wr_i.wr_data;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  assign rd_data_o = rd_data_q;

endmodule
